[design/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue: command and result
// payloads, status codes and fixed field widths.
// ----------------------------------------------------------------------------
package spq_pkg;

    // fixed field widths of the payloads
    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;
    localparam int COUNT_W = 5;
    // stored priority: sign bit dropped, negatives never stored
    localparam int KEY_W   = 7;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NEG_PRI = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_spq_status;

    // one command item
    typedef struct packed {
        logic                     cmd;
        logic [VALUE_W-1:0]       in_value;
        logic signed [PRIO_W-1:0] in_priority;
    } t_spq_in;

    // one result item
    typedef struct packed {
        t_spq_status        status;
        logic [VALUE_W-1:0] out_value;
        logic               out_valid;
        logic [VALUE_W-1:0] head_value;
        logic               head_valid;
        logic [COUNT_W-1:0] count;
    } t_spq_out;

endpackage

[design/stable_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Bounded priority queue, highest priority first, equal priorities in
// arrival order. Push inserts by parallel compare and shift, pop removes
// the head; every command returns status, head peek and count.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+-----------------------
//   command | in        | i_in_valid / o_in_ready | i_in_data  (t_spq_in)
//   result  | out       | o_out_valid/ i_out_ready| o_out_data (t_spq_out)
//
// One command per cycle is taken while the result is not stalled. The command
// register is loaded at the transfer edge and the result register when that
// command executes; the result then transfers from the result register.
// The combinational compare-and-shift over the entry array sets the rate.
// Reset empties the queue; entry contents are not cleared.
// A stalled result holds the command register, and the input stalls then.
// ----------------------------------------------------------------------------
module stable_priority_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spq_pkg::t_spq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spq_pkg::t_spq_out o_out_data
);

    spq_pkg::t_spq_in  r_in;
    logic              r_in_valid;
    spq_pkg::t_spq_out r_out;
    logic              r_out_valid;
    spq_pkg::t_spq_out res;
    logic              exec;

    // command executes when the result register is free or draining
    assign exec       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;

    spq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (exec),
        .i_cmd   (r_in),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/spq_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_store
// Sorted entry array. Compares the new priority against every slot in
// parallel, then shifts the array by one slot to insert or to pop the head.
// Produces the result of the command from the current and updated contents.
// ----------------------------------------------------------------------------
module spq_store #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  spq_pkg::t_spq_in  i_cmd,
    output spq_pkg::t_spq_out o_res
);

    localparam int CW = $clog2(DEPTH + 1);

    // entry storage, slot 0 is the head
    logic [DATA_WIDTH-1:0]      r_val  [DEPTH];
    logic [spq_pkg::KEY_W-1:0]  r_prio [DEPTH];
    logic [CW-1:0]              r_count;

    logic [DATA_WIDTH-1:0]      n_val  [DEPTH];
    logic [spq_pkg::KEY_W-1:0]  n_prio [DEPTH];
    logic [CW-1:0]              n_count;

    logic [DATA_WIDTH-1:0]      new_val;
    logic [spq_pkg::KEY_W-1:0]  new_prio;
    logic [DEPTH-1:0]           ge;
    logic                       is_neg;
    logic                       is_full;
    logic                       is_empty;
    logic                       do_push;
    logic                       do_pop;
    logic [63:0]                pop_wide;
    logic [63:0]                head_wide;
    spq_pkg::t_spq_status       status;

    assign new_val  = DATA_WIDTH'(i_cmd.in_value);
    assign new_prio = i_cmd.in_priority[spq_pkg::KEY_W-1:0];
    assign is_neg   = i_cmd.in_priority[spq_pkg::PRIO_W-1];
    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // command decode and status
    always_comb begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        status  = spq_pkg::ST_OK;
        if (i_cmd.cmd == spq_pkg::CMD_PUSH) begin
            if (is_neg) begin
                status = spq_pkg::ST_NEG_PRI;
            end else if (is_full) begin
                status = spq_pkg::ST_FULL;
            end else begin
                do_push = 1'b1;
            end
        end else begin
            if (is_empty) begin
                status = spq_pkg::ST_EMPTY;
            end else begin
                do_pop = 1'b1;
            end
        end
    end

    // parallel compare: prefix of slots that stay ahead of the new entry
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_prio[i] >= new_prio);
        end
    end

    // next contents: insert shifts toward the tail, pop shifts toward the head
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_val[i]  = r_val[i];
            n_prio[i] = r_prio[i];
            if (do_push && !ge[i]) begin
                if (i == 0 || ge[(i == 0) ? 0 : i - 1]) begin
                    n_val[i]  = new_val;
                    n_prio[i] = new_prio;
                end else begin
                    n_val[i]  = r_val[(i == 0) ? 0 : i - 1];
                    n_prio[i] = r_prio[(i == 0) ? 0 : i - 1];
                end
            end else if (do_pop && i < DEPTH - 1) begin
                n_val[i]  = r_val[(i < DEPTH - 1) ? i + 1 : i];
                n_prio[i] = r_prio[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // result of this command
    assign pop_wide  = do_pop ? 64'(r_val[0]) : '0;
    assign head_wide = (n_count != '0) ? 64'(n_val[0]) : '0;

    always_comb begin
        o_res.status     = status;
        o_res.out_value  = pop_wide[spq_pkg::VALUE_W-1:0];
        o_res.out_valid  = do_pop;
        o_res.head_value = head_wide[spq_pkg::VALUE_W-1:0];
        o_res.head_valid = (n_count != '0);
        o_res.count      = spq_pkg::COUNT_W'(n_count);
    end

    // entry storage update
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_val[i]  <= n_val[i];
                r_prio[i] <= n_prio[i];
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

endmodule
